/* design/cppf_pkg.sv */
// Shared types and constants for the coded probe pair filter.
package cppf_pkg;

  localparam int unsigned NUM_PHASES = 3;
  localparam int unsigned STAMP_W    = 64;
  localparam int unsigned ERR_W      = 16;
  localparam int unsigned PHASE_W    = 2;
  localparam int unsigned TARGET_W   = 6;

  localparam int unsigned IN_DATA_W  = 200;
  localparam int unsigned OUT_DATA_W = 216;
  localparam int unsigned APB_DATA_W = 64;
  localparam int unsigned APB_ADDR_W = 4;

  localparam logic [STAMP_W-1:0] ALL_ONES        = '1;
  localparam logic [ERR_W-1:0]   ERR_SAT         = '1;
  localparam logic [ERR_W-1:0]   THRESHOLD_RESET = 16'd50;
  localparam logic [STAMP_W-1:0] LIMIT_RESET     = 64'd99999999;

  typedef enum logic [1:0] {
    MODE_PROBE = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_READ  = 2'd2
  } mode_e;

  // Register index as decoded from paddr[3] (8-byte spacing).
  typedef enum logic {
    REG_THRESHOLD = 1'b0,
    REG_LIMIT     = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [STAMP_W-1:0] client;
    logic [STAMP_W-1:0] server;
    logic [STAMP_W-1:0] completion;
  } entry_t;

endpackage

/* design/cppf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module cppf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/coded_probe_pair_filter.sv */
// Top level of the coded probe pair filter: pairing, purity test, fastest-probe table.
//
//  channel   | dir | handshake                | content
//  s_axis    | in  | tvalid / tready          | probe, clear or read request
//  m_axis    | out | tvalid / tready          | one result per request
//  apb       | in  | psel, penable, pready=1  | purity_threshold @0, completion_limit @8
//
// Sustained rate is one request per cycle while m_axis_tready stays high; a request
// passes the request register, where the table RAM read lands, then the result register.
// Reset clears the pair parity, the table valid bits and both pipeline stages;
// the table RAM itself needs no clearing pass.
// When the result is not taken, the stage behind it holds and s_axis_tready drops
// once both are full.
module coded_probe_pair_filter #(
  parameter int unsigned MAX_SERVERS = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // phase_index, target, client_stamp, server_stamp, completion
  input  logic [cppf_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // mode
  input  logic [1:0]                           s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // pair_done, pair_pure, entry_updated, pair_error, entry_valid,
  // entry_client, entry_server, entry_completion, zero fill
  output logic [cppf_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [cppf_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [cppf_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [cppf_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready
);

  import cppf_pkg::*;

  localparam int unsigned TABLE_DEPTH = NUM_PHASES * MAX_SERVERS;
  localparam int unsigned SLOT_W      = $clog2(TABLE_DEPTH);

  // configuration
  logic [ERR_W-1:0]   threshold_q;
  logic [STAMP_W-1:0] limit_q;
  logic               cfg_wr;
  reg_idx_e           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[3]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RESET;
      limit_q     <= LIMIT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_THRESHOLD: threshold_q <= pwdata[ERR_W-1:0];
        REG_LIMIT:     limit_q     <= pwdata;
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_THRESHOLD: prdata = {{(APB_DATA_W-ERR_W){1'b0}}, threshold_q};
      REG_LIMIT:     prdata = limit_q;
      default:       prdata = '0;
    endcase
  end

  // input decode
  logic [PHASE_W-1:0]  in_phase;
  logic [TARGET_W-1:0] in_target;
  logic                in_addr_ok;
  logic [SLOT_W-1:0]   in_slot;
  logic                in_accept;
  logic                s1_ready;

  assign in_phase   = s_axis_tdata[1:0];
  assign in_target  = s_axis_tdata[7:2];
  assign in_addr_ok = (32'(in_phase) < NUM_PHASES) && (32'(in_target) < MAX_SERVERS);
  assign in_slot    = SLOT_W'(32'(in_phase) * MAX_SERVERS + 32'(in_target));
  assign in_accept  = s_axis_tvalid & s1_ready;
  assign s_axis_tready = s1_ready;

  // stage 1: request register, table read in flight
  logic               s1_valid_q;
  mode_e              s1_mode_q;
  logic               s1_addr_ok_q;
  logic [SLOT_W-1:0]  s1_slot_q;
  logic [STAMP_W-1:0] s1_client_q;
  logic [STAMP_W-1:0] s1_server_q;
  logic [STAMP_W-1:0] s1_comp_q;
  logic               s1_adv;
  logic               out_valid_q;

  assign s1_adv   = s1_valid_q & (~out_valid_q | m_axis_tready);
  assign s1_ready = ~s1_valid_q | s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_mode_q    <= mode_e'(s_axis_tuser);
      s1_addr_ok_q <= in_addr_ok;
      s1_slot_q    <= in_addr_ok ? in_slot : '0;
      s1_client_q  <= s_axis_tdata[71:8];
      s1_server_q  <= s_axis_tdata[135:72];
      s1_comp_q    <= s_axis_tdata[199:136];
    end
  end

  // table storage
  entry_t             ram_rdata;
  entry_t             wr_entry;
  logic               wr_en;
  logic [TABLE_DEPTH-1:0] valid_q;

  cppf_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_slot_q),
    .wdata_i (wr_entry),
    .re_i    (in_accept),
    .raddr_i (in_addr_ok ? in_slot : '0),
    .rdata_o (ram_rdata)
  );

  // last write, forwarded when the read raced it
  logic              byp_valid_q;
  logic [SLOT_W-1:0] byp_slot_q;
  entry_t            byp_entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_valid_q <= 1'b0;
    end else if (wr_en) begin
      byp_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      byp_slot_q  <= s1_slot_q;
      byp_entry_q <= wr_entry;
    end
  end

  // pair state
  logic               parity_q;
  logic [STAMP_W-1:0] first_client_q;
  logic [STAMP_W-1:0] first_server_q;
  logic [STAMP_W-1:0] first_comp_q;

  // stage 1 evaluation
  entry_t             stored;
  logic               stored_valid;
  logic [STAMP_W-1:0] stored_comp;
  logic               is_probe;
  logic               is_second;
  logic [STAMP_W-1:0] client_delta;
  logic [STAMP_W-1:0] server_delta;
  logic [STAMP_W-1:0] err;
  logic               impure;
  logic [ERR_W-1:0]   err_out;
  logic               upd;
  logic               post_valid;
  entry_t             post_entry;

  always_comb begin
    stored       = (byp_valid_q && byp_slot_q == s1_slot_q) ? byp_entry_q : ram_rdata;
    stored_valid = s1_addr_ok_q && valid_q[s1_slot_q];
    stored_comp  = stored_valid ? stored.completion : ALL_ONES;

    is_probe  = (s1_mode_q == MODE_PROBE);
    is_second = is_probe & parity_q;

    client_delta = s1_client_q - first_client_q;
    server_delta = s1_server_q - first_server_q;
    err = (server_delta > client_delta) ? server_delta - client_delta
                                        : client_delta - server_delta;
    impure = (first_server_q == '0) || (s1_server_q == '0) ||
             (first_comp_q > limit_q) || (s1_comp_q > limit_q);
    err_out = impure ? ERR_SAT
                     : ((err > STAMP_W'(ERR_SAT)) ? ERR_SAT : err[ERR_W-1:0]);

    upd = is_second && !impure && (err < STAMP_W'(threshold_q)) &&
          s1_addr_ok_q && (s1_comp_q < stored_comp);

    wr_entry.client     = s1_client_q;
    wr_entry.server     = s1_server_q;
    wr_entry.completion = s1_comp_q;
    wr_en = s1_adv & upd;

    // entry as it stands after this request
    if (upd) begin
      post_valid = 1'b1;
      post_entry = wr_entry;
    end else if (s1_mode_q == MODE_CLEAR) begin
      post_valid = 1'b0;
      post_entry = stored;
    end else begin
      post_valid = stored_valid;
      post_entry = stored;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parity_q       <= 1'b0;
      first_client_q <= '0;
      first_server_q <= '0;
      first_comp_q   <= ALL_ONES;
      valid_q        <= '0;
    end else if (s1_adv) begin
      case (s1_mode_q)
        MODE_PROBE: begin
          parity_q <= ~parity_q;
          if (!parity_q) begin
            first_client_q <= s1_client_q;
            first_server_q <= s1_server_q;
            first_comp_q   <= s1_comp_q;
          end
          if (upd) begin
            valid_q[s1_slot_q] <= 1'b1;
          end
        end
        MODE_CLEAR: valid_q <= '0;
        default:    ;
      endcase
    end
  end

  // result register
  logic               res_done_q;
  logic               res_pure_q;
  logic               res_upd_q;
  logic [ERR_W-1:0]   res_err_q;
  logic               res_valid_q;
  entry_t             res_entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_done_q  <= is_second;
      res_pure_q  <= is_second & ~impure;
      res_upd_q   <= upd;
      res_err_q   <= is_second ? err_out : '0;
      res_valid_q <= post_valid;
      if (post_valid) begin
        res_entry_q <= post_entry;
      end else begin
        res_entry_q.client     <= '0;
        res_entry_q.server     <= '0;
        res_entry_q.completion <= ALL_ONES;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000,
                          res_entry_q.completion,
                          res_entry_q.server,
                          res_entry_q.client,
                          res_valid_q,
                          res_err_q,
                          res_upd_q,
                          res_pure_q,
                          res_done_q};

endmodule
